// File: src/trdiv_pkg.sv
// Package for the trial-division prime tester: widths and limits.
// No dependencies; imported by trial_division_prime_test.
package trdiv_pkg;

  localparam int unsigned NUM_WIDTH   = 32;
  // Divisors stay below 2^(NUM_WIDTH/2)+1 since k*k < n.
  localparam int unsigned K_WIDTH     = NUM_WIDTH / 2 + 1;
  localparam int unsigned SQ_WIDTH    = NUM_WIDTH + 1;
  localparam int unsigned BIT_CNT_W   = $clog2(NUM_WIDTH);
  localparam int unsigned TRIES_WIDTH = 16;
  localparam int unsigned TOTAL_WIDTH = 48;

  localparam logic [K_WIDTH-1:0] FIRST_DIVISOR = K_WIDTH'(2);
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(NUM_WIDTH - 1);
  localparam logic [TRIES_WIDTH-1:0] TRIES_MAX = '1;

endpackage

// File: src/trial_division_prime_test.sv
// Trial-division prime tester, top level.
// Uses trdiv_pkg for widths and limits.
//
// Usage:
//   Raise start_i with candidate_i; the beat is taken on a clock edge where
//   start_i is high and busy_o is low. busy_o stays high while the candidate
//   is worked on. One result beat follows: done_o is high for one cycle with
//   is_prime_o, tries_o and total_tries_o. The receiver cannot stall; the
//   result must be taken in that cycle.
//   Divisors k = 2, 3, ... are tried while k*k < n. Each try runs one
//   restoring division of n by k, one dividend bit per cycle, after a
//   k*k < n check. One candidate is worked on at a time.
//   total_tries_o is a saturating 48-bit running sum of tries.
//   Reset clears the running sum and returns the block to idle.
module trial_division_prime_test
  import trdiv_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NUM_WIDTH-1:0]   candidate_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic                   is_prime_o,
  output logic [TRIES_WIDTH-1:0] tries_o,
  output logic [TOTAL_WIDTH-1:0] total_tries_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [NUM_WIDTH-1:0]   n_q, n_d;
  logic [NUM_WIDTH-1:0]   dvd_q, dvd_d;     // dividend shift register
  logic [K_WIDTH-1:0]     k_q, k_d;
  logic [K_WIDTH-1:0]     rem_q, rem_d;
  logic [SQ_WIDTH-1:0]    sq_q, sq_d;       // k*k, kept incrementally
  logic [BIT_CNT_W-1:0]   bit_q, bit_d;
  logic [K_WIDTH-1:0]     count_q, count_d;
  logic                   prime_q, prime_d;
  logic [TOTAL_WIDTH-1:0] total_q, total_d;
  logic                   done_q, done_d;
  logic                   is_prime_q, is_prime_d;
  logic [TRIES_WIDTH-1:0] tries_q, tries_d;

  logic [K_WIDTH:0]       rem_shift;
  logic [K_WIDTH:0]       rem_sub;
  logic [K_WIDTH-1:0]     rem_next;
  logic [TOTAL_WIDTH:0]   total_sum;

  // One restoring division step: shift in the next dividend bit.
  always_comb begin
    rem_shift = {rem_q, dvd_q[NUM_WIDTH-1]};
    rem_sub   = rem_shift - {1'b0, k_q};
    rem_next  = rem_sub[K_WIDTH] ? rem_shift[K_WIDTH-1:0] : rem_sub[K_WIDTH-1:0];
  end

  assign total_sum = {1'b0, total_q} + (TOTAL_WIDTH + 1)'(count_q);

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    dvd_d      = dvd_q;
    k_d        = k_q;
    rem_d      = rem_q;
    sq_d       = sq_q;
    bit_d      = bit_q;
    count_d    = count_q;
    prime_d    = prime_q;
    total_d    = total_q;
    done_d     = 1'b0;
    is_prime_d = is_prime_q;
    tries_d    = tries_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          n_d     = candidate_i;
          k_d     = FIRST_DIVISOR;
          sq_d    = SQ_WIDTH'(4);
          count_d = '0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sq_q < {1'b0, n_q}) begin
          count_d = count_q + K_WIDTH'(1);
          dvd_d   = n_q;
          rem_d   = '0;
          bit_d   = '0;
          state_d = ST_DIV;
        end else begin
          // no divisor below sqrt(n): prime unless n < 2 or n is k*k
          prime_d = (n_q >= NUM_WIDTH'(2)) && (sq_q != {1'b0, n_q});
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        rem_d = rem_next;
        dvd_d = {dvd_q[NUM_WIDTH-2:0], 1'b0};
        bit_d = bit_q + BIT_CNT_W'(1);
        if (bit_q == LAST_BIT) begin
          if (rem_next == '0) begin
            prime_d = 1'b0;
            state_d = ST_FIN;
          end else begin
            // (k+1)^2 = k^2 + 2k + 1
            sq_d    = sq_q + SQ_WIDTH'({k_q, 1'b1});
            k_d     = k_q + K_WIDTH'(1);
            state_d = ST_CHECK;
          end
        end
      end
      ST_FIN: begin
        total_d    = total_sum[TOTAL_WIDTH] ? '1 : total_sum[TOTAL_WIDTH-1:0];
        is_prime_d = prime_q;
        tries_d    = (count_q > K_WIDTH'(TRIES_MAX)) ? TRIES_MAX
                                                    : count_q[TRIES_WIDTH-1:0];
        done_d     = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    dvd_q      <= dvd_d;
    k_q        <= k_d;
    rem_q      <= rem_d;
    sq_q       <= sq_d;
    bit_q      <= bit_d;
    count_q    <= count_d;
    prime_q    <= prime_d;
    is_prime_q <= is_prime_d;
    tries_q    <= tries_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign is_prime_o    = is_prime_q;
  assign tries_o       = tries_q;
  assign total_tries_o = total_q;

endmodule
